// ----- design/rtmh_pkg.sv -----
// Package for the round-half-up-to-multiple block.
// Holds the status codes and the per-stage control struct; no dependencies.
`timescale 1ns / 1ps

package rtmh_pkg;

  localparam int FIELD_WIDTH = 64;
  localparam int STATUS_WIDTH = 2;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_STEP = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE    = 2'd2;

  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic [STATUS_WIDTH-1:0] status;
  } ctrl_t;

endpackage

// ----- design/rtmh_if.sv -----
// Channel interfaces for the round-half-up-to-multiple block.
// Depends on rtmh_pkg for field widths.
`timescale 1ns / 1ps

interface rtmh_in_if;
  logic                                valid;
  logic                                ready;
  logic [rtmh_pkg::FIELD_WIDTH-1:0]    price;
  logic [rtmh_pkg::FIELD_WIDTH-1:0]    step;

  modport source (output valid, output price, output step, input ready);
  modport sink (input valid, input price, input step, output ready);
endinterface

interface rtmh_out_if;
  logic                                valid;
  logic                                ready;
  logic [rtmh_pkg::FIELD_WIDTH-1:0]    rounded;
  logic [rtmh_pkg::STATUS_WIDTH-1:0]   status;

  modport source (output valid, output rounded, output status, input ready);
  modport sink (input valid, input rounded, input status, output ready);
endinterface

// ----- design/rtmh_prep.sv -----
// Front stages: input register, sign split with bias, and biased dividend.
// Depends on rtmh_pkg.
`timescale 1ns / 1ps

module rtmh_prep #(
  parameter int W = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [W-1:0]         price,
  input  logic [W-1:0]         step,
  output rtmh_pkg::ctrl_t      ctrl,
  output logic [W-1:0]         dividend,
  output logic [W-1:0]         divisor,
  output logic [W-1:0]         value
);

  logic            v1;
  logic [W-1:0]    x1;
  logic [W-1:0]    t1;

  rtmh_pkg::ctrl_t c2;
  rtmh_pkg::ctrl_t c2_next;
  logic [W-1:0]    x2;
  logic [W-1:0]    t2;
  logic [W-1:0]    mag;
  logic [W-1:0]    mag_next;
  logic [W-1:0]    half;
  logic [W-1:0]    half_next;

  always_comb begin
    c2_next.valid = v1;
    c2_next.neg = x1[W-1];
    if ((t1 == '0) || t1[W-1]) begin
      c2_next.status = rtmh_pkg::STATUS_BAD_STEP;
    end else begin
      c2_next.status = rtmh_pkg::STATUS_OK;
    end
    mag_next = x1[W-1] ? (~x1 + W'(1)) : x1;
    half_next = x1[W-1] ? ((t1 - W'(1)) >> 1) : (t1 >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      c2.valid <= 1'b0;
      ctrl.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      c2.valid <= c2_next.valid;
      ctrl.valid <= c2.valid;
    end
    if (en) begin
      x1 <= price;
      t1 <= step;
      c2.neg <= c2_next.neg;
      c2.status <= c2_next.status;
      x2 <= x1;
      t2 <= t1;
      mag <= mag_next;
      half <= half_next;
      ctrl.neg <= c2.neg;
      ctrl.status <= c2.status;
      dividend <= mag + half;
      divisor <= t2;
      value <= x2;
    end
  end

endmodule

// ----- design/rtmh_div_stage.sv -----
// One restoring-division step: shifts in one dividend bit and subtracts
// the divisor when it fits. Only the remainder is kept. Depends on rtmh_pkg.
`timescale 1ns / 1ps

module rtmh_div_stage #(
  parameter int W = 64,
  parameter int I = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  rtmh_pkg::ctrl_t      ctrl_in,
  input  logic [W-1:0]         dividend_in,
  input  logic [W-1:0]         divisor_in,
  input  logic [W-1:0]         value_in,
  input  logic [W-1:0]         rem_in,
  output rtmh_pkg::ctrl_t      ctrl,
  output logic [W-1:0]         dividend,
  output logic [W-1:0]         divisor,
  output logic [W-1:0]         value,
  output logic [W-1:0]         rem
);

  localparam int BIT = W - 1 - I;

  logic [W-1:0] shifted;
  logic [W-1:0] rem_next;

  always_comb begin
    shifted = {rem_in[W-2:0], dividend_in[BIT]};
    rem_next = (shifted >= divisor_in) ? (shifted - divisor_in) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= ctrl_in.valid;
    end
    if (en) begin
      ctrl.neg <= ctrl_in.neg;
      ctrl.status <= ctrl_in.status;
      dividend <= dividend_in;
      divisor <= divisor_in;
      value <= value_in;
      rem <= rem_next;
    end
  end

endmodule

// ----- design/rtmh_finish.sv -----
// Back stages: rounded magnitude from dividend minus remainder, then range
// check, sign restore and the output register. Depends on rtmh_pkg.
`timescale 1ns / 1ps

module rtmh_finish #(
  parameter int W = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  rtmh_pkg::ctrl_t                      ctrl_in,
  input  logic [W-1:0]                         dividend_in,
  input  logic [W-1:0]                         value_in,
  input  logic [W-1:0]                         rem_in,
  output logic                                 out_valid,
  output logic [rtmh_pkg::FIELD_WIDTH-1:0]     rounded,
  output logic [rtmh_pkg::STATUS_WIDTH-1:0]    status
);

  localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};

  rtmh_pkg::ctrl_t c1;
  logic [W-1:0]    total;
  logic [W-1:0]    x1;
  logic [W-1:0]    limit;
  logic [W-1:0]    res;
  logic [W-1:0]    res_next;
  logic [rtmh_pkg::STATUS_WIDTH-1:0] status_next;

  always_comb begin
    limit = c1.neg ? SIGN_BIT : (SIGN_BIT - W'(1));
    res = c1.neg ? (~total + W'(1)) : total;
    status_next = c1.status;
    res_next = x1;
    if (c1.status == rtmh_pkg::STATUS_OK) begin
      if (total > limit) begin
        status_next = rtmh_pkg::STATUS_RANGE;
      end else begin
        res_next = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      c1.valid <= ctrl_in.valid;
      out_valid <= c1.valid;
    end
    if (en) begin
      c1.neg <= ctrl_in.neg;
      c1.status <= ctrl_in.status;
      total <= dividend_in - rem_in;
      x1 <= value_in;
      rounded <= rtmh_pkg::FIELD_WIDTH'($signed(res_next));
      status <= status_next;
    end
  end

endmodule

// ----- design/round_to_multiple_half_up.sv -----
// Top level of the round-half-up-to-multiple block.
// Depends on rtmh_pkg, rtmh_if, rtmh_prep, rtmh_div_stage and rtmh_finish.
//
// The block rounds a signed value (price) to the nearest multiple of a
// positive step, with exact halves going toward plus infinity. Only the low
// VALUE_WIDTH bits of each input are used; the result is sign-extended.
// Input items arrive on the in channel and results leave on the out channel,
// both valid/ready; a transfer happens when valid and ready are both high.
// Status is 0 when rounded, 1 when the step is zero or negative and 2 when
// the rounded value is out of range; in the last two cases price is passed
// back unchanged.
// The pipeline has three front stages, one restoring division step per stage
// for each dividend bit, and two back stages. Throughput is one item per cycle
// while the receiver does not stall; the division pipeline sets this.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in.ready drops; nothing is lost or repeated. Reset clears all valid
// bits, and the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module round_to_multiple_half_up #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  rtmh_in_if.sink     in,
  rtmh_out_if.source  out
);

  localparam int W = VALUE_WIDTH;

  logic advance;

  rtmh_pkg::ctrl_t ctrl_s [W+1];
  logic [W-1:0]    dividend_s [W+1];
  logic [W-1:0]    divisor_s [W+1];
  logic [W-1:0]    value_s [W+1];
  logic [W-1:0]    rem_s [W+1];
  logic [W-1:0]    div_valid;

  assign advance = !out.valid || out.ready;
  assign in.ready = advance;
  assign rem_s[0] = '0;

  rtmh_prep #(
    .W(W)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (in.valid),
    .price    (in.price[W-1:0]),
    .step     (in.step[W-1:0]),
    .ctrl     (ctrl_s[0]),
    .dividend (dividend_s[0]),
    .divisor  (divisor_s[0]),
    .value    (value_s[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_div
    rtmh_div_stage #(
      .W(W),
      .I(i)
    ) u_stage (
      .clk         (clk),
      .rst         (rst),
      .en          (advance),
      .ctrl_in     (ctrl_s[i]),
      .dividend_in (dividend_s[i]),
      .divisor_in  (divisor_s[i]),
      .value_in    (value_s[i]),
      .rem_in      (rem_s[i]),
      .ctrl        (ctrl_s[i+1]),
      .dividend    (dividend_s[i+1]),
      .divisor     (divisor_s[i+1]),
      .value       (value_s[i+1]),
      .rem         (rem_s[i+1])
    );
    assign div_valid[i] = ctrl_s[i+1].valid;
  end

  rtmh_finish #(
    .W(W)
  ) u_finish (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .ctrl_in     (ctrl_s[W]),
    .dividend_in (dividend_s[W]),
    .value_in    (value_s[W]),
    .rem_in      (rem_s[W]),
    .out_valid   (out.valid),
    .rounded     (out.rounded),
    .status      (out.status)
  );

  // The status code that means nothing is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> (out.status != 2'd3))
    else $error("round_to_multiple_half_up: undefined status code");

  // While the output stalls, the division stages neither advance nor drop items.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> $stable(div_valid))
    else $error("round_to_multiple_half_up: pipeline moved during stall");

  // Items leaving the division pipeline with a valid step have a remainder below it.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl_s[W].valid && (ctrl_s[W].status == rtmh_pkg::STATUS_OK))
      |-> (rem_s[W] < divisor_s[W]))
    else $error("round_to_multiple_half_up: remainder not below step");

endmodule
